// ===== hdl/plcm_pkg.sv =====
// Shared constants, types and codes of the piecewise-linear contrast map.
package plcm_pkg;

   localparam int MAX_POINTS  = 64;
   localparam int ADDR_BITS   = $clog2(MAX_POINTS);
   localparam int COUNT_BITS  = 7;
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 8;
   localparam int OUT_BITS    = SAMPLE_BITS + FRAC_BITS;
   // Dividend of the interpolation: |dy| * dist, scaled by the fraction bits.
   localparam int DIV_BITS    = 2 * SAMPLE_BITS + FRAC_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_BITS);
   // Shared subtractor: wide enough for any difference of two samples and
   // for a shifted remainder minus the divisor.
   localparam int SUB_BITS    = SAMPLE_BITS + 2;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic        [ADDR_BITS-1:0]   index_type;
   typedef logic        [COUNT_BITS-1:0]  count_type;
   typedef logic signed [OUT_BITS-1:0]    result_type;
   typedef logic        [1:0]             flag_type;
   typedef logic                          op_type;

   localparam count_type RESET_POINT_COUNT = count_type'(2);

   localparam op_type OP_LOAD = 1'b0;
   localparam op_type OP_MAP  = 1'b1;

   localparam flag_type FLAG_INTERP     = 2'd0;
   localparam flag_type FLAG_CLAMP_LOW  = 2'd1;
   localparam flag_type FLAG_CLAMP_HIGH = 2'd2;

endpackage

// ===== hdl/plcm_if.sv =====
// Handshake channels of the piecewise-linear contrast map: request, response, register write.
interface plcm_req_if;
   logic                 valid;
   logic                 ready;
   plcm_pkg::op_type     op;
   plcm_pkg::index_type  point_index;
   plcm_pkg::sample_type point_x;
   plcm_pkg::sample_type point_y;
   plcm_pkg::sample_type sample;

   modport source (output valid, op, point_index, point_x, point_y, sample, input ready);
   modport sink   (input valid, op, point_index, point_x, point_y, sample, output ready);
endinterface

interface plcm_rsp_if;
   logic                 valid;
   logic                 ready;
   plcm_pkg::result_type mapped_value;
   plcm_pkg::flag_type   range_flag;

   modport source (output valid, mapped_value, range_flag, input ready);
   modport sink   (input valid, mapped_value, range_flag, output ready);
endinterface

interface plcm_csr_if;
   logic                valid;
   logic                ready;
   plcm_pkg::count_type point_count;

   modport source (output valid, point_count, input ready);
   modport sink   (input valid, point_count, output ready);
endinterface

// ===== hdl/piecewise_linear_contrast_map.sv =====
// Top level of the piecewise-linear contrast map: breakpoint table, sequencer and shared subtractor.
//
//   channel  direction  payload                                        transfer when
//   req_ch   in         op, point_index, point_x, point_y, sample      valid & ready
//   rsp_ch   out        mapped_value, range_flag                       valid & ready
//   csr_ch   in         point_count                                    valid & ready
//
// A load item is written straight into the table and the block stays ready for the next item.
// A map item ends clamped low after the compare with the first breakpoint, clamped
// high after the compare with the last breakpoint in use, and otherwise goes on to
// a linear search for the segment and an interpolation. The search reads the table one
// entry per cycle through its single read port, and the quotient comes out of a
// restoring division of 40 steps, one bit per cycle, on the shared subtractor.
// Reset is synchronous and clears the sequencer, the response valid and the point
// count (back to two); the table holds whatever it held until it is written.
// A stalled response stays in the output register while the next item is taken;
// a finished map result waits in its last state until that register is free.
module piecewise_linear_contrast_map (
   input logic       clock,
   input logic       reset,
   plcm_req_if.sink  req_ch,
   plcm_rsp_if.source rsp_ch,
   plcm_csr_if.sink  csr_ch
);
   import plcm_pkg::*;

   // Sequencer states.
   localparam logic [3:0] ST_IDLE = 4'd0;   // waiting for a request
   localparam logic [3:0] ST_CHK0 = 4'd1;   // compare with the first breakpoint
   localparam logic [3:0] ST_CHKN = 4'd2;   // compare with the last breakpoint in use
   localparam logic [3:0] ST_SRCH = 4'd3;   // linear search for the segment
   localparam logic [3:0] ST_DX   = 4'd4;   // x1 - x0
   localparam logic [3:0] ST_DY   = 4'd5;   // y1 - y0, split into sign and magnitude
   localparam logic [3:0] ST_DIST = 4'd6;   // sample - x0
   localparam logic [3:0] ST_MUL  = 4'd7;   // |dy| * dist, loads the dividend
   localparam logic [3:0] ST_DIV  = 4'd8;   // one quotient bit per cycle
   localparam logic [3:0] ST_FIN  = 4'd9;   // y0 scaled, plus or minus the quotient
   localparam logic [3:0] ST_DONE = 4'd10;  // hand the result to the output register

   logic [3:0] state_ff, state_in;

   // The breakpoint table keeps x in the upper half of a word and y in the lower.
   logic [2*SAMPLE_BITS-1:0] curve_mem [MAX_POINTS];
   logic [2*SAMPLE_BITS-1:0] rd_data_ff;
   index_type                rd_addr;
   sample_type               rd_x, rd_y;

   count_type  point_count_ff, point_count_in;
   count_type  active_points;
   index_type  last_index;

   sample_type sample_ff, sample_in;
   index_type  last_ff, last_in;
   index_type  idx_ff, idx_in;
   sample_type prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   sample_type cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [SAMPLE_BITS-1:0]  dx_ff, dx_in;
   logic [SAMPLE_BITS-1:0]  dy_mag_ff, dy_mag_in;
   logic                    dy_neg_ff, dy_neg_in;
   logic [SAMPLE_BITS-1:0]  dist_ff, dist_in;
   logic [DIV_BITS-1:0]     quo_ff, quo_in;
   logic [SAMPLE_BITS-1:0]  rem_ff, rem_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   result_type result_ff, result_in;
   flag_type   flag_ff, flag_in;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_value_ff, rsp_value_in;
   flag_type   rsp_flag_ff, rsp_flag_in;

   // Shared subtractor and the operands the sequencer steers into it.
   logic signed [SUB_BITS-1:0] sub_a, sub_b, sub_diff;
   logic                       diff_neg, diff_zero;
   logic [SAMPLE_BITS:0]       rem_shift;
   logic signed [SUB_BITS-1:0] dy_abs;
   result_type                 y0_scaled;
   result_type                 quotient;

   logic req_accept;
   logic load_accept;
   logic map_accept;
   logic out_free;

   assign req_accept  = req_ch.valid && req_ch.ready;
   assign load_accept = req_accept && (req_ch.op == OP_LOAD);
   assign map_accept  = req_accept && (req_ch.op == OP_MAP);
   assign out_free    = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign csr_ch.ready        = 1'b1;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.mapped_value = rsp_value_ff;
   assign rsp_ch.range_flag   = rsp_flag_ff;

   // A zero count behaves as one breakpoint, and a count past the table saturates.
   always_comb begin
      if (point_count_ff == '0) begin
         active_points = count_type'(1);
      end else if (point_count_ff > count_type'(MAX_POINTS)) begin
         active_points = count_type'(MAX_POINTS);
      end else begin
         active_points = point_count_ff;
      end
   end

   always_comb begin
      count_type last_wide;
      last_wide  = active_points - count_type'(1);
      last_index = last_wide[ADDR_BITS-1:0];
   end

   assign rd_x = rd_data_ff[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign rd_y = rd_data_ff[SAMPLE_BITS-1:0];

   // The read address is steered ahead of the state that uses the data, since the table read is registered.
   always_comb begin
      unique case (state_ff)
         ST_IDLE: rd_addr = '0;
         ST_CHK0: rd_addr = last_ff;
         ST_CHKN: rd_addr = index_type'(1);
         ST_SRCH: rd_addr = idx_ff + index_type'(1);
         default: rd_addr = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_accept) begin
         curve_mem[req_ch.point_index] <= {req_ch.point_x, req_ch.point_y};
      end
      rd_data_ff <= curve_mem[rd_addr];
   end

   assign rem_shift = {rem_ff, quo_ff[DIV_BITS-1]};

   always_comb begin
      unique case (state_ff)
         ST_DX: begin
            sub_a = SUB_BITS'(cur_x_ff);
            sub_b = SUB_BITS'(prev_x_ff);
         end
         ST_DY: begin
            sub_a = SUB_BITS'(cur_y_ff);
            sub_b = SUB_BITS'(prev_y_ff);
         end
         ST_DIST: begin
            sub_a = SUB_BITS'(sample_ff);
            sub_b = SUB_BITS'(prev_x_ff);
         end
         ST_DIV: begin
            sub_a = {1'b0, rem_shift};
            sub_b = {2'b00, dx_ff};
         end
         default: begin
            sub_a = SUB_BITS'(sample_ff);
            sub_b = SUB_BITS'(rd_x);
         end
      endcase
   end

   assign sub_diff  = sub_a - sub_b;
   assign diff_neg  = sub_diff[SUB_BITS-1];
   assign diff_zero = (sub_diff == '0);
   assign dy_abs    = diff_neg ? -sub_diff : sub_diff;
   assign y0_scaled = {prev_y_ff, FRAC_BITS'(0)};
   assign quotient  = quo_ff[OUT_BITS-1:0];

   always_comb begin
      state_in       = state_ff;
      point_count_in = point_count_ff;
      sample_in      = sample_ff;
      last_in        = last_ff;
      idx_in         = idx_ff;
      prev_x_in      = prev_x_ff;
      prev_y_in      = prev_y_ff;
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      dx_in          = dx_ff;
      dy_mag_in      = dy_mag_ff;
      dy_neg_in      = dy_neg_ff;
      dist_in        = dist_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      cnt_in         = cnt_ff;
      result_in      = result_ff;
      flag_in        = flag_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_flag_in    = rsp_flag_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;

      if (csr_ch.valid && csr_ch.ready) begin
         point_count_in = csr_ch.point_count;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (map_accept) begin
               sample_in = req_ch.sample;
               last_in   = last_index;
               state_in  = ST_CHK0;
            end
         end
         ST_CHK0: begin
            prev_x_in = rd_x;
            prev_y_in = rd_y;
            if (diff_neg || diff_zero) begin
               result_in = {rd_y, FRAC_BITS'(0)};
               flag_in   = FLAG_CLAMP_LOW;
               state_in  = ST_DONE;
            end else begin
               state_in  = ST_CHKN;
            end
         end
         ST_CHKN: begin
            if (!diff_neg) begin
               result_in = {rd_y, FRAC_BITS'(0)};
               flag_in   = FLAG_CLAMP_HIGH;
               state_in  = ST_DONE;
            end else begin
               idx_in    = index_type'(1);
               state_in  = ST_SRCH;
            end
         end
         ST_SRCH: begin
            // Keep going while this breakpoint is not the last and lies below the sample.
            if ((idx_ff != last_ff) && !diff_neg && !diff_zero) begin
               prev_x_in = rd_x;
               prev_y_in = rd_y;
               idx_in    = idx_ff + index_type'(1);
            end else begin
               cur_x_in  = rd_x;
               cur_y_in  = rd_y;
               state_in  = ST_DX;
            end
         end
         ST_DX: begin
            dx_in    = sub_diff[SAMPLE_BITS-1:0];
            state_in = ST_DY;
         end
         ST_DY: begin
            dy_neg_in = diff_neg;
            dy_mag_in = dy_abs[SAMPLE_BITS-1:0];
            state_in  = ST_DIST;
         end
         ST_DIST: begin
            dist_in  = sub_diff[SAMPLE_BITS-1:0];
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // The product keeps its full width of two samples.
            quo_in   = {(2*SAMPLE_BITS)'(dy_mag_ff) * (2*SAMPLE_BITS)'(dist_ff),
                        FRAC_BITS'(0)};
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!diff_neg) begin
               rem_in = sub_diff[SAMPLE_BITS-1:0];
               quo_in = {quo_ff[DIV_BITS-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[SAMPLE_BITS-1:0];
               quo_in = {quo_ff[DIV_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff + DIV_CNT_BITS'(1);
            if (cnt_ff == DIV_CNT_BITS'(DIV_BITS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            result_in = dy_neg_ff ? (y0_scaled - quotient) : (y0_scaled + quotient);
            flag_in   = FLAG_INTERP;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = result_ff;
               rsp_flag_in  = flag_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         point_count_ff <= RESET_POINT_COUNT;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         point_count_ff <= point_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      last_ff      <= last_in;
      idx_ff       <= idx_in;
      prev_x_ff    <= prev_x_in;
      prev_y_ff    <= prev_y_in;
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      dx_ff        <= dx_in;
      dy_mag_ff    <= dy_mag_in;
      dy_neg_ff    <= dy_neg_in;
      dist_ff      <= dist_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      result_ff    <= result_in;
      flag_ff      <= flag_in;
      rsp_value_ff <= rsp_value_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

   // A map request always starts the sequencer and closes the request side.
   a_map_starts: assert property (@(posedge clock) disable iff (reset)
      map_accept |=> (state_ff == ST_CHK0) && !req_ch.ready)
      else $error("map request did not start the sequencer");

   // A new response only comes out of the final sequencer state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_ch.ready)) |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside the final state");

   // The quotient is finished only after the full count of division steps.
   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |->
         ($past(state_ff) == ST_DIV) && ($past(cnt_ff) == DIV_CNT_BITS'(DIV_BITS - 1)))
      else $error("division left before its last step");

   // While the output is stalled, a finished result stays in the final state and its register holds.
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && !out_free) |=> (state_ff == ST_DONE) && $stable(result_ff))
      else $error("finished result lost while the output was stalled");

endmodule
